/* rtl/core/tjs_pkg.sv */
// Package for the timestamp judder smoother core.
// Holds sizes, the sequencer state type and the multiply-accumulate request
// and response types. It depends on nothing else.
package tjs_pkg;

    // Ring and cycle sizing.
    localparam int MAX_CYCLE   = 240;
    localparam int MIN_CYCLE   = 2;
    localparam int RESET_CYCLE = 4;
    localparam int RING_DEPTH  = MAX_CYCLE + 2;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int CYC_W       = 8;

    // Timestamp widths.
    localparam int PTS_IN_W = 55;
    localparam int PTS_W    = 64;
    localparam int HALF_W   = PTS_W / 2;

    // Multiplier coefficient width, wide enough for twice the longest cycle.
    localparam int COEF_W = $clog2(2 * MAX_CYCLE + 1);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_DECIDE,
        S_SHIFT,
        S_MAC_GO,
        S_MAC_WAIT,
        S_FIN
    } tjs_state_t;

    // Request to the multiply-accumulate unit.
    typedef struct packed {
        logic              start;
        logic [PTS_W-1:0]  base;
        logic [PTS_W-1:0]  op0;
        logic [COEF_W-1:0] k0;
        logic [PTS_W-1:0]  op1;
        logic [COEF_W-1:0] k1;
        logic              two_terms;
    } mac_req_t;

    // Response from the multiply-accumulate unit.
    typedef struct packed {
        logic             done;
        logic [PTS_W-1:0] result;
    } mac_rsp_t;

endpackage

/* rtl/core/tjs_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the timestamp ring. It depends on nothing else.
module tjs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/tjs_mac.sv */
// Multiply-accumulate unit for the smoother tally.
// Adds one or two products of a 64-bit operand and a small coefficient to a base,
// one 32-bit half per cycle. Depends on tjs_pkg.
module tjs_mac
    import tjs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mac_req_t req,
    output mac_rsp_t rsp
);

    logic [PTS_W-1:0]         acc_reg;
    logic [PTS_W-1:0]         op0_reg;
    logic [PTS_W-1:0]         op1_reg;
    logic [COEF_W-1:0]        k0_reg;
    logic [COEF_W-1:0]        k1_reg;
    logic                     two_reg;
    logic [1:0]               step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [PTS_W-1:0]         op_sel;
    logic [COEF_W-1:0]        k_sel;
    logic [HALF_W-1:0]        half_op;
    logic [HALF_W+COEF_W-1:0] prod;
    logic [PTS_W-1:0]         addend;
    logic                     last_step;

    // Pick the term and half for this step, then form the shifted partial product.
    always_comb begin
        op_sel    = step_reg[1] ? op1_reg : op0_reg;
        k_sel     = step_reg[1] ? k1_reg : k0_reg;
        half_op   = step_reg[0] ? op_sel[PTS_W-1:HALF_W] : op_sel[HALF_W-1:0];
        prod      = (HALF_W+COEF_W)'(half_op) * (HALF_W+COEF_W)'(k_sel);
        addend    = step_reg[0] ? {prod[HALF_W-1:0], {HALF_W{1'b0}}} : PTS_W'(prod);
        last_step = (step_reg == 2'd3) || (step_reg == 2'd1 && !two_reg);
    end

    // Control: run two or four steps after a start, then pulse done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= busy_reg && last_step;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: load operands on start, accumulate while busy.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            acc_reg <= req.base;
            op0_reg <= req.op0;
            op1_reg <= req.op1;
            k0_reg  <= req.k0;
            k1_reg  <= req.k1;
            two_reg <= req.two_terms;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + addend;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

/* rtl/core/timestamp_judder_smoother_core.sv */
// Top level of the timestamp judder smoother.
// Sequencer, index and tally registers around the ring RAM and the MAC unit.
// Depends on tjs_pkg, tjs_ram and tjs_mac.
//
// Takes one frame timestamp per word and returns one smoothed timestamp in a
// time base 2*C times finer, C being cycle_length clamped to 2..MAX_CYCLE.
// One word is worked on at a time. A word without a timestamp passes straight
// to the output register. During warm-up a word goes straight to the multiply-accumulate
// unit; afterwards it also takes four reads through the single read port of the
// ring RAM and four 32-bit multiply-accumulate steps. A timestamp that steps
// backward adds a walk of the whole ring through the RAM, one entry per cycle.
// A finished word waits in the output register while the next word is taken in.
// Writing cycle_length restarts the smoother but keeps the ring contents.
module timestamp_judder_smoother_core
    import tjs_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration
    input  logic                       cfg_wr_en,
    input  logic [CYC_W-1:0]           cfg_wr_data,
    // Input words
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [PTS_IN_W-1:0] s_in_pts,
    input  logic                       s_in_valid,
    // Result words
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [PTS_W-1:0]    m_out_pts,
    output logic                       m_out_valid
);

    tjs_state_t state_reg, state_next;

    logic [CYC_W-1:0] cycle_reg;
    logic [IDX_W-1:0] oldest_reg, second_reg, third_reg, newest_reg;
    logic [PTS_W-1:0] tally_reg;
    logic [CNT_W-1:0] warm_left_reg;

    logic [PTS_W-1:0] pts_reg;
    logic             item_valid_reg;
    logic             warm_item_reg;

    logic [2:0]       rd_cnt_reg;
    logic [PTS_W-1:0] r_reg [4];
    logic [PTS_W-1:0] d1_reg, d2_reg, offset_reg;
    logic             lt_reg;
    logic [CNT_W-1:0] sh_cnt_reg;

    logic             m_valid_reg;
    logic [PTS_W-1:0] m_pts_reg;
    logic             m_flag_reg;

    logic             s_acc;
    logic             out_free;
    logic [CNT_W-1:0] size;
    logic [CNT_W-1:0] newest_plus;
    logic [CYC_W-1:0] cfg_clamped;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [PTS_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [PTS_W-1:0] ram_rdata;

    mac_req_t         mac_req;
    mac_rsp_t         mac_rsp;

    // Handshake qualifiers and ring size.
    assign s_acc       = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign size        = CNT_W'(cycle_reg) + CNT_W'(2);
    assign newest_plus = CNT_W'(newest_reg) + CNT_W'(1);

    // Clamp a written cycle length into the supported range.
    always_comb begin
        if (cfg_wr_data < CYC_W'(MIN_CYCLE)) begin
            cfg_clamped = CYC_W'(MIN_CYCLE);
        end else if (cfg_wr_data > CYC_W'(MAX_CYCLE)) begin
            cfg_clamped = CYC_W'(MAX_CYCLE);
        end else begin
            cfg_clamped = cfg_wr_data;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (!s_in_valid) begin
                        state_next = S_FIN;
                    end else if (warm_left_reg != '0) begin
                        state_next = S_MAC_GO;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                if (rd_cnt_reg == 3'd4) begin
                    state_next = S_CMP;
                end
            end
            S_CMP:    state_next = S_DECIDE;
            S_DECIDE: state_next = lt_reg ? S_SHIFT : S_MAC_GO;
            S_SHIFT: begin
                if (sh_cnt_reg == size) begin
                    state_next = S_MAC_GO;
                end
            end
            S_MAC_GO: state_next = S_MAC_WAIT;
            S_MAC_WAIT: begin
                if (mac_rsp.done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: ready, RAM ports and the MAC request.
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = second_reg;
        ram_wdata = pts_reg;
        ram_raddr = oldest_reg;
        mac_req   = '0;
        case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_READ: begin
                case (rd_cnt_reg[1:0])
                    2'd0:    ram_raddr = oldest_reg;
                    2'd1:    ram_raddr = second_reg;
                    2'd2:    ram_raddr = third_reg;
                    default: ram_raddr = newest_reg;
                endcase
            end
            S_SHIFT: begin
                // Read entry k while writing back entry k-1 with the offset added.
                ram_raddr = sh_cnt_reg[IDX_W-1:0];
                ram_we    = (sh_cnt_reg != '0);
                ram_waddr = IDX_W'(sh_cnt_reg - CNT_W'(1));
                ram_wdata = ram_rdata + offset_reg;
            end
            S_MAC_GO: begin
                mac_req.start     = 1'b1;
                mac_req.base      = warm_item_reg ? '0 : tally_reg;
                mac_req.op0       = warm_item_reg ? pts_reg : d1_reg;
                mac_req.k0        = warm_item_reg ? COEF_W'({cycle_reg, 1'b0})
                                                  : COEF_W'(cycle_reg) - COEF_W'(1);
                mac_req.op1       = d2_reg;
                mac_req.k1        = COEF_W'(cycle_reg) + COEF_W'(1);
                mac_req.two_terms = !warm_item_reg;
            end
            S_FIN: begin
                ram_we    = out_free && item_valid_reg;
                ram_waddr = second_reg;
                ram_wdata = pts_reg;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control state, indices, tally and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cycle_reg     <= CYC_W'(RESET_CYCLE);
            oldest_reg    <= IDX_W'(0);
            second_reg    <= IDX_W'(1);
            third_reg     <= IDX_W'(2);
            newest_reg    <= IDX_W'(3);
            tally_reg     <= '0;
            warm_left_reg <= CNT_W'(RESET_CYCLE + 2);
            rd_cnt_reg    <= '0;
            sh_cnt_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (s_acc) begin
                rd_cnt_reg <= '0;
                sh_cnt_reg <= '0;
            end
            if (state_reg == S_READ) begin
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
            end
            if (state_reg == S_SHIFT) begin
                sh_cnt_reg <= sh_cnt_reg + CNT_W'(1);
            end
            if (state_reg == S_MAC_WAIT && mac_rsp.done) begin
                tally_reg <= mac_rsp.result;
            end

            // Hand the word to the output register and advance the ring.
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                if (item_valid_reg) begin
                    oldest_reg <= second_reg;
                    second_reg <= third_reg;
                    third_reg  <= newest_reg;
                    newest_reg <= (newest_plus == size) ? '0 : newest_plus[IDX_W-1:0];
                    if (warm_item_reg) begin
                        warm_left_reg <= warm_left_reg - CNT_W'(1);
                    end
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // A cycle length write restarts the smoother.
            if (cfg_wr_en) begin
                cycle_reg     <= cfg_clamped;
                oldest_reg    <= IDX_W'(0);
                second_reg    <= IDX_W'(1);
                third_reg     <= IDX_W'(2);
                newest_reg    <= IDX_W'(3);
                tally_reg     <= '0;
                warm_left_reg <= CNT_W'(cfg_clamped) + CNT_W'(2);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pts_reg        <= {{(PTS_W-PTS_IN_W){s_in_pts[PTS_IN_W-1]}}, s_in_pts};
            item_valid_reg <= s_in_valid;
            warm_item_reg  <= (warm_left_reg != '0);
        end
        // Collect oldest, second, third and newest as they come out of the RAM.
        if (state_reg == S_READ && rd_cnt_reg != 3'd0) begin
            r_reg[0] <= r_reg[1];
            r_reg[1] <= r_reg[2];
            r_reg[2] <= r_reg[3];
            r_reg[3] <= ram_rdata;
        end
        if (state_reg == S_CMP) begin
            d1_reg <= r_reg[2] - r_reg[0];
            d2_reg <= pts_reg - r_reg[3];
            lt_reg <= $signed(pts_reg) < $signed(r_reg[1]);
        end
        // After the shift the newest difference becomes the negated first one.
        if (state_reg == S_DECIDE && lt_reg) begin
            offset_reg <= d1_reg + d2_reg;
            d2_reg     <= '0 - d1_reg;
        end
        if (state_reg == S_FIN && out_free) begin
            m_pts_reg  <= item_valid_reg ? tally_reg : pts_reg;
            m_flag_reg <= item_valid_reg;
        end
    end

    tjs_ram #(
        .WIDTH(PTS_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    tjs_mac u_mac (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mac_req),
        .rsp    (mac_rsp)
    );

    assign m_valid     = m_valid_reg;
    assign m_out_pts   = m_pts_reg;
    assign m_out_valid = m_flag_reg;

    // The ring walk never writes past the active ring size.
    a_shift_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && ram_we) |-> (CNT_W'(ram_waddr) < size))
        else $error("ring walk wrote beyond the ring size");

    // The newest index stays inside the active ring while a word is worked on.
    a_newest_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (CNT_W'(newest_reg) < size))
        else $error("newest index outside the ring");

    // The MAC only finishes while the sequencer waits for it.
    a_mac_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_rsp.done |-> (state_reg == S_MAC_WAIT))
        else $error("MAC finished outside of its wait state");

    // A finished word that leaves S_FIN always reaches the output register.
    a_word_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> m_valid_reg)
        else $error("finished word did not reach the output register");

endmodule

/* verif/tb_timestamp_judder_smoother_core.sv */
// Testbench for timestamp_judder_smoother_core: directed table, then random judder streams.
// Every result word is checked against a built-in smoother model, or for typed directed rows a table value.
// Depends on tjs_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_timestamp_judder_smoother_core
    import tjs_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int END_PAUSE      = 40;
    localparam int MAX_PRINTED    = 100;
    localparam int NDIR           = 24;

    // One expected result word.
    typedef struct packed {
        logic [PTS_W-1:0] pts;
        logic             vld;
    } smoothed_t;

    // One directed row; typed rows carry their expected timestamp.
    typedef struct packed {
        logic [PTS_IN_W-1:0] pts;
        logic                vld;
        logic                typed;
        logic [PTS_W-1:0]    exp_pts;
    } dir_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CYC_W-1:0]           cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [PTS_IN_W-1:0] s_in_pts;
    logic                       s_in_valid;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [PTS_W-1:0]    m_out_pts;
    logic                       m_out_valid;

    // Smoother model state.
    logic [PTS_W-1:0] ring_ts [RING_DEPTH];
    int               idx_old;
    int               idx_sec;
    int               idx_thr;
    int               idx_new;
    logic [PTS_W-1:0] tally_ts;
    int               warm_cnt;
    logic [CYC_W-1:0] cycle_reg;

    smoothed_t smoothed_q [$];
    int        mismatches   = 0;
    int        results_seen = 0;
    bit        idle_on      = 1'b1;
    bit        hold_done    = 1'b0;

    // Reset defaults first, then extremes, then a judder run with a backward step.
    dir_row_t dir_tbl [NDIR] = '{
        '{55'h3F_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'h003F_FFFF_FFFF_FFFF},
        '{55'h40_0000_0000_0000, 1'b0, 1'b1, 64'hFFC0_0000_0000_0000},
        '{55'h00_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000},
        '{55'h3F_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h01FF_FFFF_FFFF_FFF8},
        '{55'h40_0000_0000_0000, 1'b1, 1'b1, 64'hFE00_0000_0000_0000},
        '{55'h00_0000_0000_0001, 1'b1, 1'b1, 64'h0000_0000_0000_0008},
        '{55'h7F_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8},
        '{55'd100,               1'b1, 1'b1, 64'd800},
        '{55'd1000,              1'b1, 1'b0, 64'd0},
        '{55'd2100,              1'b1, 1'b0, 64'd0},
        '{55'd2900,              1'b1, 1'b0, 64'd0},
        '{55'd4000,              1'b1, 1'b0, 64'd0},
        '{55'd5100,              1'b1, 1'b0, 64'd0},
        '{55'h15_5555_5555_5555, 1'b0, 1'b1, 64'h0015_5555_5555_5555},
        '{55'd5900,              1'b1, 1'b0, 64'd0},
        '{55'd7000,              1'b1, 1'b0, 64'd0},
        '{55'd8100,              1'b1, 1'b0, 64'd0},
        '{55'd500,               1'b1, 1'b0, 64'd0},
        '{55'd1600,              1'b1, 1'b0, 64'd0},
        '{55'd2400,              1'b1, 1'b0, 64'd0},
        '{55'h3F_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'd0},
        '{55'h40_0000_0000_0000, 1'b1, 1'b0, 64'd0},
        '{55'h00_0000_0000_0000, 1'b0, 1'b1, 64'h0000_0000_0000_0000},
        '{55'd12345,             1'b1, 1'b0, 64'd0}
    };

    timestamp_judder_smoother_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_pts    (s_in_pts),
        .s_in_valid  (s_in_valid),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_pts   (m_out_pts),
        .m_out_valid (m_out_valid)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The cycle register is clamped into the supported range.
    function automatic int eff_cycle(input logic [CYC_W-1:0] v);
        if (v < MIN_CYCLE) return MIN_CYCLE;
        if (v > MAX_CYCLE) return MAX_CYCLE;
        return int'(v);
    endfunction

    // Indices, tally and warm-up go back to their start values; the ring is kept.
    function automatic void restart_smoother();
        idx_old  = 0;
        idx_sec  = 1;
        idx_thr  = 2;
        idx_new  = 3;
        tally_ts = '0;
        warm_cnt = eff_cycle(cycle_reg) + 2;
    endfunction

    // Works out the result word for one accepted input word and advances the model.
    function automatic void smooth_timestamp(input logic [PTS_IN_W-1:0] pts, input logic vld,
                                             output logic [PTS_W-1:0] o_pts, output logic o_vld);
        logic [PTS_W-1:0] p;
        logic [PTS_W-1:0] r1;
        logic [PTS_W-1:0] r2;
        logic [PTS_W-1:0] r3;
        logic [PTS_W-1:0] r4;
        logic [PTS_W-1:0] ofs;
        int               c;
        int               sz;
        int               k;
        p     = {{(PTS_W - PTS_IN_W){pts[PTS_IN_W-1]}}, pts};
        c     = eff_cycle(cycle_reg);
        sz    = c + 2;
        o_vld = vld;
        o_pts = p;
        if (!vld) begin
            return;
        end
        if (warm_cnt != 0) begin
            warm_cnt--;
            tally_ts = p * 64'(2 * c);
        end else begin
            r1 = ring_ts[idx_old];
            r2 = ring_ts[idx_sec];
            r3 = ring_ts[idx_thr];
            r4 = ring_ts[idx_new];
            // A backward step shifts the whole active ring by a common offset.
            if ($signed(p) < $signed(r2)) begin
                ofs = p + r3 - r4 - r1;
                for (k = 0; k < sz; k++) begin
                    ring_ts[k] = ring_ts[k] + ofs;
                end
                r1 = r1 + ofs;
                r3 = r3 + ofs;
                r4 = r4 + ofs;
            end
            tally_ts = tally_ts + 64'(c - 1) * (r3 - r1) + 64'(c + 1) * (p - r4);
        end
        ring_ts[idx_sec] = p;
        idx_old = idx_sec;
        idx_sec = idx_thr;
        idx_thr = idx_new;
        idx_new = (idx_new + 1) % sz;
        o_pts   = tally_ts;
    endfunction

    // Random gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    task automatic report_mismatch(input string what, input logic [PTS_W-1:0] got,
                                   input logic [PTS_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch on %s at result word %0d: got %h, expected %h",
                     what, results_seen, got, want);
        end
    endtask

    // Offers one input word; entered and left at a falling edge.
    task automatic send_word(input logic [PTS_IN_W-1:0] pts, input logic vld,
                             input logic typed, input logic [PTS_W-1:0] typed_pts);
        int        gap;
        smoothed_t e;
        gap = pick_gap();
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_pts   <= pts;
        s_in_valid <= vld;
        do @(posedge aclk); while (!s_ready);
        smooth_timestamp(pts, vld, e.pts, e.vld);
        if (typed) begin
            e.pts = typed_pts;
        end
        smoothed_q.push_back(e);
        @(negedge aclk);
    endtask

    // Waits for every expected word, then lets the block settle.
    task automatic drain();
        while (smoothed_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // The register is written only while the block is empty.
    task automatic write_cycle(input logic [CYC_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cycle_reg = v;
        restart_smoother();
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Judder stream with random content: a nominal frame step plus a repeating
    // pattern, with occasional backward jumps, noise and words without a timestamp.
    task automatic run_phase(input logic [CYC_W-1:0] cyc_val, input int n_valid, input bit idle);
        logic [PTS_W-1:0] base_ts;
        logic [PTS_W-1:0] ts;
        int               jud [MAX_CYCLE];
        int               step;
        int               plen;
        int               frame;
        int               nv;
        int               r;
        int               k;
        idle_on = idle;
        write_cycle(cyc_val);
        plen    = eff_cycle(cyc_val);
        step    = $urandom_range(1, 1 << 20);
        base_ts = {$urandom, $urandom};
        for (k = 0; k < plen; k++) begin
            jud[k] = $urandom_range(0, step);
        end
        frame = 0;
        nv    = 0;
        while (nv < n_valid) begin
            r  = $urandom_range(0, 99);
            ts = {$urandom, $urandom};
            if (r < 7) begin
                send_word(ts[PTS_IN_W-1:0], 1'b0, 1'b0, '0);
            end else if (r < 11) begin
                send_word(ts[PTS_IN_W-1:0], 1'b1, 1'b0, '0);
                nv++;
            end else begin
                if (r < 15 || nv == n_valid - 4) begin
                    base_ts = base_ts - 64'($urandom_range(2, 40)) * 64'(step);
                end
                ts = base_ts + 64'(frame) * 64'(step) + 64'(jud[frame % plen]);
                send_word(ts[PTS_IN_W-1:0], 1'b1, 1'b0, '0);
                frame++;
                nv++;
            end
        end
        s_valid <= 1'b0;
        drain();
    endtask

    // Stimulus.
    initial begin
        int i;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_in_pts    = '0;
        s_in_valid  = 1'b0;
        cycle_reg   = CYC_W'(RESET_CYCLE);
        restart_smoother();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows run at the reset cycle length.
        for (i = 0; i < NDIR; i++) begin
            send_word(dir_tbl[i].pts, dir_tbl[i].vld, dir_tbl[i].typed, dir_tbl[i].exp_pts);
        end
        s_valid <= 1'b0;
        drain();

        run_phase(8'd0, 20, 1'b1);
        run_phase(8'd1, 10, 1'b0);
        run_phase(8'd2, 15, 1'b1);
        run_phase(8'd3, 15, 1'b1);
        run_phase(8'd5, 15, 1'b0);
        run_phase(CYC_W'($urandom_range(6, 20)), 30, 1'b1);
        run_phase(8'd241, 12, 1'b1);
        run_phase(8'd255, 252, 1'b1);
        run_phase(8'd240, 8, 1'b0);
        run_phase(8'd4, 15, 1'b1);
        run_phase(CYC_W'($urandom_range(2, 12)), 20, 1'b1);

        drain();
        repeat (END_PAUSE) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb_timestamp_judder_smoother_core: PASS");
        end else begin
            $display("tb_timestamp_judder_smoother_core: FAIL");
        end
        $finish;
    end

    // Result side ready: random gaps, plus one long hold-off so the block backs up.
    initial begin
        int gap;
        gap     = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
                gap = pick_gap();
            end
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge aclk) begin
        smoothed_t e;
        if (aresetn && m_valid && m_ready) begin
            if (smoothed_q.size() == 0) begin
                report_mismatch("unexpected word", m_out_pts, '0);
            end else begin
                e = smoothed_q.pop_front();
                if (m_out_pts !== e.pts) begin
                    report_mismatch("out_pts", m_out_pts, e.pts);
                end
                if (m_out_valid !== e.vld) begin
                    report_mismatch("out_valid", 64'(m_out_valid), 64'(e.vld));
                end
            end
            results_seen++;
        end
    end

    // Watchdog: too many cycles in a row with no word moving on either side.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_timestamp_judder_smoother_core: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tjs_pkg.sv
rtl/core/tjs_ram.sv
rtl/core/tjs_mac.sv
rtl/core/timestamp_judder_smoother_core.sv
verif/tb_timestamp_judder_smoother_core.sv
